// ----- sv/kpht_pkg.sv -----
package kpht_pkg;

  localparam int KEY_W        = 4;
  localparam int TIME_W       = 32;
  localparam int PHASE_W      = 2;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int NUM_KEYS_DEF = 16;
  // wide enough to hold any key count up to 256
  localparam int IDX_W        = 9;

  localparam logic [TIME_W-1:0] HOLD_RESET = 32'd1000;
  localparam logic [TIME_W-1:0] IDLE_RESET = 32'd200;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_HOLD     = 2'd2,
    PH_RELEASED = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_THRESHOLD = 4'd0,
    REG_IDLE_THRESHOLD = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] hold_threshold;
    logic [TIME_W-1:0] idle_threshold;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] stamp;
  } key_entry_t;

  localparam key_entry_t KEY_ENTRY_RESET = '{phase: PH_IDLE, stamp: '0};

  typedef struct packed {
    logic              changed;
    key_entry_t        entry;
  } key_wr_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic              key_level;
    logic [TIME_W-1:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_number;
    logic [PHASE_W-1:0] key_phase;
    logic               phase_changed;
  } out_item_t;

endpackage

// ----- sv/kpht_if.sv -----
interface kpht_in_if;
  logic               valid;
  logic               ready;
  kpht_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kpht_out_if;
  logic                valid;
  logic                ready;
  kpht_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/kpht_cfg.sv -----
module kpht_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [kpht_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kpht_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output kpht_pkg::cfg_t                     cfg
);

  kpht_pkg::cfg_t cfg_r;
  kpht_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        kpht_pkg::REG_HOLD_THRESHOLD: cfg_nxt.hold_threshold = cfg_wdata;
        kpht_pkg::REG_IDLE_THRESHOLD: cfg_nxt.idle_threshold = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_threshold <= kpht_pkg::HOLD_RESET;
      cfg_r.idle_threshold <= kpht_pkg::IDLE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/kpht_state_mem.sv -----
module kpht_state_mem #(
  parameter int NUM_KEYS = kpht_pkg::NUM_KEYS_DEF,
  parameter int AW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  kpht_pkg::key_entry_t   wr_data,
  output kpht_pkg::key_entry_t   rd_data
);

  kpht_pkg::key_entry_t mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]  valid_r;
  kpht_pkg::key_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // an entry never written reads as idle with a zero stamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // write-first: a read of the address written in the same cycle sees the new entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else if (valid_r[rd_addr]) begin
        rd_data_r <= mem[rd_addr];
      end else begin
        rd_data_r <= kpht_pkg::KEY_ENTRY_RESET;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/kpht_update.sv -----
module kpht_update (
  input  kpht_pkg::cfg_t          cfg,
  input  kpht_pkg::in_item_t      item,
  input  logic                    in_range,
  input  kpht_pkg::key_entry_t    cur,
  output kpht_pkg::key_wr_t       upd,
  output kpht_pkg::out_item_t     result
);

  logic [kpht_pkg::TIME_W-1:0] elapsed;
  kpht_pkg::phase_t            new_phase;
  logic                        changed;

  assign elapsed = item.time_now - cur.stamp;

  always_comb begin
    new_phase = cur.phase;
    if (item.key_level) begin
      case (cur.phase)
        kpht_pkg::PH_IDLE:    new_phase = kpht_pkg::PH_PRESSED;
        kpht_pkg::PH_PRESSED: begin
          if (elapsed > cfg.hold_threshold) begin
            new_phase = kpht_pkg::PH_HOLD;
          end
        end
        // presses while released are ignored, hold stays hold
        default: new_phase = cur.phase;
      endcase
    end else if (cur.phase != kpht_pkg::PH_IDLE) begin
      new_phase = (elapsed > cfg.idle_threshold) ? kpht_pkg::PH_IDLE
                                                 : kpht_pkg::PH_RELEASED;
    end
  end

  assign changed = in_range && (new_phase != cur.phase);

  always_comb begin
    upd.changed      = changed;
    upd.entry.phase  = new_phase;
    upd.entry.stamp  = item.time_now;

    result.key_number    = item.key_index;
    result.key_phase     = in_range ? new_phase : kpht_pkg::PH_IDLE;
    result.phase_changed = changed;
  end

endmodule

// ----- sv/key_press_hold_release_tracker.sv -----
// Key press/hold/release tracker. Each item on in_ch is one sample of one key
// (index, level, timestamp); each produces exactly one item on out_ch with the
// key's new phase (0 idle, 1 pressed, 2 hold, 3 released) and whether it changed.
// Elapsed time is the wrapping 32-bit difference to the key's last phase change,
// compared strictly against hold_threshold (register 0, reset 1000) and
// idle_threshold (register 1, reset 200). Keys at or above NUM_KEYS report idle
// and unchanged. Throughput is one item per clock unless out_ch stalls. Each key's
// state is read from the per-key state memory through a registered read at
// acceptance, with same-key back-to-back samples forwarded around it. No
// clearing pass is needed after reset. Write the thresholds only while idle.
module key_press_hold_release_tracker #(
  parameter int NUM_KEYS = kpht_pkg::NUM_KEYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  kpht_in_if.sink                           in_ch,
  kpht_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [kpht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kpht_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int PAD_W = kpht_pkg::IDX_W - kpht_pkg::KEY_W;

  kpht_pkg::cfg_t       cfg;
  kpht_pkg::key_entry_t cur;
  kpht_pkg::key_wr_t    upd;
  kpht_pkg::out_item_t  result;

  logic                 s1_valid_r, s1_valid_nxt;
  kpht_pkg::in_item_t   s1_item_r;
  logic                 out_valid_r, out_valid_nxt;
  kpht_pkg::out_item_t  out_item_r;

  logic                         advance;
  logic                         accept;
  logic [kpht_pkg::IDX_W-1:0]   in_key_ext;
  logic [kpht_pkg::IDX_W-1:0]   s1_key_ext;
  logic                         s1_in_range;

  assign advance = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign accept = in_ch.valid && in_ch.ready;

  assign in_key_ext  = {{PAD_W{1'b0}}, in_ch.data.key_index};
  assign s1_key_ext  = {{PAD_W{1'b0}}, s1_item_r.key_index};
  assign s1_in_range = s1_key_ext < kpht_pkg::IDX_W'(NUM_KEYS);

  kpht_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kpht_state_mem #(
    .NUM_KEYS (NUM_KEYS),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_key_ext[AW-1:0]),
    .wr_en   (advance && upd.changed),
    .wr_addr (s1_key_ext[AW-1:0]),
    .wr_data (upd.entry),
    .rd_data (cur)
  );

  kpht_update u_update (
    .cfg      (cfg),
    .item     (s1_item_r),
    .in_range (s1_in_range),
    .cur      (cur),
    .upd      (upd),
    .result   (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_ch.data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule
